@@ rtl/rcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotated chessboard pattern generator package
// Shared widths, fixed-point constants, register indexes and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpg_pkg;

  // Port and field widths.
  localparam int IN_W       = 12;
  localparam int DIM_W      = 13;
  localparam int TRIG_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;

  // Fixed-point formats.
  localparam int FRAC_W     = 8;          // rotated coordinates are Q.8
  localparam int Q14_TO_Q8  = 6;          // Q.14 product down to Q.8
  localparam int ROUND_Q8   = 32;         // half an LSB of Q.8 in Q.14
  localparam int WEIGHT_ONE = 256;        // 1.0 in Q.8
  localparam int HALF_Q16   = 32768;      // 0.5 in Q.16
  localparam int CELL_SHIFT = 4;          // 16-pixel cells

  // Shade constants.
  localparam int PIX_MAX    = 255;
  localparam int SHADE_MID  = 128;
  localparam int MID_LIMIT  = 1024;       // 4.0 in Q.8

  // Reset values of the configuration registers.
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int COS_RST          = 16384;
  localparam int SIN_RST          = 0;

  // Register stages from input to output register.
  localparam int PIPE_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COS          = 2'd2,
    REG_SIN          = 2'd3
  } cfg_reg_e;

  // Width of the rotated Q.8 coordinates for a given coordinate width.
  function automatic int q8_width(input int coord_bits);
    int xw;
    xw = (coord_bits > IN_W) ? coord_bits : IN_W;
    // offset (xw+1), product (+TRIG_W), sum and rounding (+2), then Q.14 -> Q.8
    return xw + 1 + TRIG_W + 2 - Q14_TO_Q8;
  endfunction

  // Width of a cell shade for a given Q.8 coordinate width.
  function automatic int shade_width(input int q8_w);
    return q8_w - FRAC_W - 2;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rcpg_rotate.sv @@
// ----------------------------------------------------------------------------
// Rotation stages
// Offsets the pixel from the frame center, rotates it with the cosine and
// sine registers and rounds the result to signed Q.8, over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpg_rotate #(
  parameter int COORD_BITS = 12,
  localparam int QW = rcpg_pkg::q8_width(COORD_BITS)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [COORD_BITS-1:0]             col_i,
  input  wire logic [COORD_BITS-1:0]             row_i,
  input  wire logic [rcpg_pkg::DIM_W-2:0]        half_w_i,
  input  wire logic [rcpg_pkg::DIM_W-2:0]        half_h_i,
  input  wire logic signed [rcpg_pkg::TRIG_W-1:0] cos_i,
  input  wire logic signed [rcpg_pkg::TRIG_W-1:0] sin_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [QW-1:0]                   x_q8_o,
  output logic signed [QW-1:0]                   y_q8_o
);

  import rcpg_pkg::*;

  localparam int XW = (COORD_BITS > DIM_W - 1) ? COORD_BITS : DIM_W - 1;
  localparam int DW = XW + 1;
  localparam int PW = TRIG_W + DW;
  localparam int RW = PW + 2;

  logic en_a, en_b, en_c;
  logic v_a_q, v_b_q, v_c_q;

  logic signed [DW-1:0] dc_d, dr_d, dc_q, dr_q;
  logic signed [PW-1:0] pcc_d, psr_d, psc_d, pcr_d;
  logic signed [PW-1:0] pcc_q, psr_q, psc_q, pcr_q;
  logic signed [RW-1:0] x_sum, y_sum;
  logic signed [QW-1:0] x_q8_d, y_q8_d, x_q8_q, y_q8_q;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    en_c = !v_c_q || out_ready_i;
    en_b = !v_b_q || en_c;
    en_a = !v_a_q || en_b;
  end

  assign in_ready_o = en_a;

  always_comb begin
    dc_d   = DW'(col_i) - DW'(half_w_i);
    dr_d   = DW'(row_i) - DW'(half_h_i);
    pcc_d  = PW'(cos_i) * PW'(dc_q);
    psr_d  = PW'(sin_i) * PW'(dr_q);
    psc_d  = PW'(sin_i) * PW'(dc_q);
    pcr_d  = PW'(cos_i) * PW'(dr_q);
    x_sum  = RW'(pcc_q) + RW'(psr_q) + RW'(ROUND_Q8);
    y_sum  = RW'(pcr_q) - RW'(psc_q) + RW'(ROUND_Q8);
    x_q8_d = QW'(x_sum >>> Q14_TO_Q8);
    y_q8_d = QW'(y_sum >>> Q14_TO_Q8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (en_a) v_a_q <= in_valid_i;
      if (en_b) v_b_q <= v_a_q;
      if (en_c) v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      dc_q <= dc_d;
      dr_q <= dr_d;
    end
    if (en_b) begin
      pcc_q <= pcc_d;
      psr_q <= psr_d;
      psc_q <= psc_d;
      pcr_q <= pcr_d;
    end
    if (en_c) begin
      x_q8_q <= x_q8_d;
      y_q8_q <= y_q8_d;
    end
  end

  assign out_valid_o = v_c_q;
  assign x_q8_o      = x_q8_q;
  assign y_q8_o      = y_q8_q;

endmodule

`default_nettype wire

@@ rtl/rcpg_cell.sv @@
// ----------------------------------------------------------------------------
// Cell stages
// Splits the rotated coordinates into integer and fraction, picks the cell
// shades and selects the shade of each of the four neighboring cells.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpg_cell #(
  parameter int Q8_W = 25,
  localparam int SW = rcpg_pkg::shade_width(Q8_W)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [Q8_W-1:0]          x_q8_i,
  input  wire logic signed [Q8_W-1:0]          y_q8_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [SW-1:0]                 c00_o,
  output logic signed [SW-1:0]                 c01_o,
  output logic signed [SW-1:0]                 c10_o,
  output logic signed [SW-1:0]                 c11_o,
  output logic signed [rcpg_pkg::FRAC_W:0]     fx_o,
  output logic signed [rcpg_pkg::FRAC_W:0]     fy_o
);

  import rcpg_pkg::*;

  localparam int IW = Q8_W - FRAC_W;
  localparam int CW = IW - CELL_SHIFT;
  localparam logic signed [Q8_W-1:0] MidHi = Q8_W'(MID_LIMIT);
  localparam logic signed [Q8_W-1:0] MidLo = Q8_W'(-MID_LIMIT);

  logic en_d, en_e;
  logic v_d_q, v_e_q;

  logic                  x_adj, y_adj;
  logic signed [IW-1:0]  ix_d, iy_d, ix_q, iy_q;
  logic signed [FRAC_W:0] fx_d, fy_d, fx_d_q, fy_d_q, fx_q, fy_q;
  logic                  mid_d, mid_q;

  logic signed [CW-1:0]  qi, qj;
  logic signed [SW-1:0]  black, white;
  logic                  pi0, pi1, pj0, pj1;
  logic signed [SW-1:0]  c00_d, c01_d, c10_d, c11_d;
  logic signed [SW-1:0]  c00_q, c01_q, c10_q, c11_q;

  always_comb begin
    en_e = !v_e_q || out_ready_i;
    en_d = !v_d_q || en_e;
  end

  assign in_ready_o = en_d;

  // Integer parts truncate toward zero, so a negative value with a nonzero
  // fraction rounds up by one and leaves a negative fraction behind.
  always_comb begin
    x_adj = x_q8_i[Q8_W-1] && (x_q8_i[FRAC_W-1:0] != '0);
    y_adj = y_q8_i[Q8_W-1] && (y_q8_i[FRAC_W-1:0] != '0);
    ix_d  = IW'(x_q8_i >>> FRAC_W) + IW'(x_adj);
    iy_d  = IW'(y_q8_i >>> FRAC_W) + IW'(y_adj);
    fx_d  = {x_adj, x_q8_i[FRAC_W-1:0]};
    fy_d  = {y_adj, y_q8_i[FRAC_W-1:0]};
    mid_d = (x_q8_i > MidLo) && (x_q8_i < MidHi) &&
            (y_q8_i > MidLo) && (y_q8_i < MidHi);
  end

  always_comb begin
    qi    = CW'(ix_q >>> CELL_SHIFT) +
            CW'(ix_q[IW-1] && (ix_q[CELL_SHIFT-1:0] != '0));
    qj    = CW'(iy_q >>> CELL_SHIFT) +
            CW'(iy_q[IW-1] && (iy_q[CELL_SHIFT-1:0] != '0));
    black = mid_q ? SW'(SHADE_MID) : SW'(qi);
    white = mid_q ? SW'(SHADE_MID) : SW'(PIX_MAX) - SW'(qj);
    // Cell parity of i+1 flips when the low cell bits of i are all ones.
    pi0   = ix_q[CELL_SHIFT];
    pi1   = ix_q[CELL_SHIFT] ^ (&ix_q[CELL_SHIFT-1:0]);
    pj0   = iy_q[CELL_SHIFT];
    pj1   = iy_q[CELL_SHIFT] ^ (&iy_q[CELL_SHIFT-1:0]);
    c00_d = (pi0 ^ pj0) ? white : black;
    c01_d = (pi1 ^ pj0) ? white : black;
    c10_d = (pi0 ^ pj1) ? white : black;
    c11_d = (pi1 ^ pj1) ? white : black;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (en_d) v_d_q <= in_valid_i;
      if (en_e) v_e_q <= v_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      ix_q   <= ix_d;
      iy_q   <= iy_d;
      fx_d_q <= fx_d;
      fy_d_q <= fy_d;
      mid_q  <= mid_d;
    end
    if (en_e) begin
      c00_q <= c00_d;
      c01_q <= c01_d;
      c10_q <= c10_d;
      c11_q <= c11_d;
      fx_q  <= fx_d_q;
      fy_q  <= fy_d_q;
    end
  end

  assign out_valid_o = v_e_q;
  assign c00_o       = c00_q;
  assign c01_o       = c01_q;
  assign c10_o       = c10_q;
  assign c11_o       = c11_q;
  assign fx_o        = fx_q;
  assign fy_o        = fy_q;

endmodule

`default_nettype wire

@@ rtl/rcpg_blend.sv @@
// ----------------------------------------------------------------------------
// Blend stages
// Bilinear blend of the four cell shades: horizontal pass, vertical pass,
// then rounding and clamping into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpg_blend #(
  parameter int SHADE_W = 15
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [SHADE_W-1:0]   c00_i,
  input  wire logic signed [SHADE_W-1:0]   c01_i,
  input  wire logic signed [SHADE_W-1:0]   c10_i,
  input  wire logic signed [SHADE_W-1:0]   c11_i,
  input  wire logic signed [rcpg_pkg::FRAC_W:0] fx_i,
  input  wire logic signed [rcpg_pkg::FRAC_W:0] fy_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rcpg_pkg::PIX_W-1:0]       pixel_value_o
);

  import rcpg_pkg::*;

  localparam int WW  = FRAC_W + 2;
  localparam int AW  = SHADE_W + FRAC_W + 3;
  localparam int TW  = AW + FRAC_W + 3;
  localparam int TTW = TW + 1;
  localparam int Q16 = 2 * FRAC_W;

  logic en_f, en_g, en_h;
  logic v_f_q, v_g_q, v_h_q;

  logic signed [WW-1:0]   wx0, wy0;
  logic signed [AW-1:0]   a0_d, a1_d, a0_q, a1_q;
  logic signed [FRAC_W:0] fy_q;
  logic signed [TW-1:0]   sum_d, sum_q;
  logic signed [TTW-1:0]  tot;
  logic [PIX_W-1:0]       pix_d, pix_q;

  always_comb begin
    en_h = !v_h_q || out_ready_i;
    en_g = !v_g_q || en_h;
    en_f = !v_f_q || en_g;
  end

  assign in_ready_o = en_f;

  always_comb begin
    wx0   = WW'(WEIGHT_ONE) - WW'(fx_i);
    a0_d  = AW'(c00_i) * AW'(wx0) + AW'(c01_i) * AW'(fx_i);
    a1_d  = AW'(c10_i) * AW'(wx0) + AW'(c11_i) * AW'(fx_i);
    wy0   = WW'(WEIGHT_ONE) - WW'(fy_q);
    sum_d = TW'(a0_q) * TW'(wy0) + TW'(a1_q) * TW'(fy_q);
  end

  // Round by one half, then clamp: negative totals give zero.
  always_comb begin
    tot = TTW'(sum_q) + TTW'(HALF_Q16);
    if (tot[TTW-1]) begin
      pix_d = '0;
    end else if (|tot[TTW-2:Q16+PIX_W]) begin
      pix_d = PIX_W'(PIX_MAX);
    end else begin
      pix_d = tot[Q16+PIX_W-1:Q16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
      v_h_q <= 1'b0;
    end else begin
      if (en_f) v_f_q <= in_valid_i;
      if (en_g) v_g_q <= v_f_q;
      if (en_h) v_h_q <= v_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f) begin
      a0_q <= a0_d;
      a1_q <= a1_d;
      fy_q <= fy_i;
    end
    if (en_g) begin
      sum_q <= sum_d;
    end
    if (en_h) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o   = v_h_q;
  assign pixel_value_o = pix_q;

endmodule

`default_nettype wire

@@ rtl/rotated_chessboard_pattern_gen.sv @@
// ----------------------------------------------------------------------------
// Rotated chessboard pattern generator
// Video test pattern: rotates each pixel about the frame center and blends
// the four nearest 16-pixel chessboard cells into one luma sample.
//
//   Channel  Direction  Signals                           Moves
//   in       input      in_valid_i/in_ready_o             col_i, row_i
//   out      output     out_valid_o/out_ready_i           pixel_value_o
//   cfg      input      cfg_valid_i/cfg_ready_o           cfg_index_i, cfg_data_i
//
// One pixel per clock when the output side keeps taking. The pipeline holds
// three rotation stages, two cell stages and three blend stages.
// Each stage holds its item while the next one is full, so bubbles close up
// and a stalled output fills the pipeline before in_ready_o drops.
// Reset empties the pipeline and loads the default 640x480 frame, angle zero.
// The configuration port takes a transfer in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_chessboard_pattern_gen #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [rcpg_pkg::IN_W-1:0]          col_i,
  input  wire logic [rcpg_pkg::IN_W-1:0]          row_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [rcpg_pkg::PIX_W-1:0]              pixel_value_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rcpg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rcpg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import rcpg_pkg::*;

  localparam int XW = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
  localparam int QW = q8_width(COORD_BITS);
  localparam int SW = shade_width(QW);

  logic [DIM_W-1:0]         frame_width_q, frame_height_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  logic [XW-1:0]            col_x, row_x;

  logic                     rot_valid, rot_ready;
  logic signed [QW-1:0]     x_q8, y_q8;
  logic                     cell_valid, cell_ready;
  logic signed [SW-1:0]     c00, c01, c10, c11;
  logic signed [FRAC_W:0]   fx, fy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(FRAME_WIDTH_RST);
      frame_height_q <= DIM_W'(FRAME_HEIGHT_RST);
      cos_q          <= TRIG_W'(COS_RST);
      sin_q          <= TRIG_W'(SIN_RST);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
        REG_COS:          cos_q          <= cfg_data_i[TRIG_W-1:0];
        REG_SIN:          sin_q          <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Only the low COORD_BITS bits of a coordinate take part.
  assign col_x = XW'(col_i);
  assign row_x = XW'(row_i);

  rcpg_rotate #(
    .COORD_BITS (COORD_BITS)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .col_i       (col_x[COORD_BITS-1:0]),
    .row_i       (row_x[COORD_BITS-1:0]),
    .half_w_i    (frame_width_q[DIM_W-1:1]),
    .half_h_i    (frame_height_q[DIM_W-1:1]),
    .cos_i       (cos_q),
    .sin_i       (sin_q),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .x_q8_o      (x_q8),
    .y_q8_o      (y_q8)
  );

  rcpg_cell #(
    .Q8_W (QW)
  ) u_cell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .x_q8_i      (x_q8),
    .y_q8_i      (y_q8),
    .out_valid_o (cell_valid),
    .out_ready_i (cell_ready),
    .c00_o       (c00),
    .c01_o       (c01),
    .c10_o       (c10),
    .c11_o       (c11),
    .fx_o        (fx),
    .fy_o        (fy)
  );

  rcpg_blend #(
    .SHADE_W (SW)
  ) u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cell_valid),
    .in_ready_o    (cell_ready),
    .c00_i         (c00),
    .c01_i         (c01),
    .c10_i         (c10),
    .c11_i         (c11),
    .fx_i          (fx),
    .fy_i          (fy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o)
  );

endmodule

`default_nettype wire

@@ rtl/rcpg_checker.sv @@
// ----------------------------------------------------------------------------
// Rotated chessboard pattern generator checker
// Port-level checks on handshake behavior and on items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [rcpg_pkg::PIX_W-1:0]    pixel_value_o
);

  import rcpg_pkg::*;

  localparam int CntW = $clog2(PIPE_DEPTH + 2);

  logic            in_xfer, out_xfer;
  logic [CntW-1:0] cnt_d, cnt_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + CntW'(in_xfer) - CntW'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A waiting result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o))
    else $error("stalled result changed or vanished");

  // An empty output stage means the pipeline can take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output is empty");

  // No result without an accepted item still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result shown with no item in flight");

  // The pipeline never holds more items than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind rotated_chessboard_pattern_gen rcpg_checker u_rcpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_value_o (pixel_value_o)
);

`default_nettype wire

@@ dv/tb_rotated_chessboard_pattern_gen.sv @@
// ----------------------------------------------------------------------------
// Rotated chessboard pattern generator testbench
// Sends pixel coordinates under several frame sizes and rotation angles and
// compares every generated luma sample with a bit-exact predictor of the
// rotate, cell-select and bilinear-blend arithmetic. The input idles and the
// output stalls at random, in separate phases and then together.
// ----------------------------------------------------------------------------

module tb_rotated_chessboard_pattern_gen;
  import rcpg_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int RANDOM_ITEMS = 950;
  localparam int SEGMENTS     = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [IN_W-1:0]       col_i       = '0;
  logic [IN_W-1:0]       row_i       = '0;
  logic                  out_ready_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      pixel_value_o;
  logic                  cfg_ready_o;

  // Register copies used by the predictor.
  logic [DIM_W-1:0]         frame_w = DIM_W'(FRAME_WIDTH_RST);
  logic [DIM_W-1:0]         frame_h = DIM_W'(FRAME_HEIGHT_RST);
  logic signed [TRIG_W-1:0] cos_w   = TRIG_W'(COS_RST);
  logic signed [TRIG_W-1:0] sin_w   = TRIG_W'(SIN_RST);

  logic [PIX_W-1:0] expected_pixels[$];
  logic [PIX_W-1:0] want_pixel;
  int               send_idle_pct   = 0;
  int               ready_stall_pct = 0;
  int               mismatches      = 0;
  int               cycle_count     = 0;

  rotated_chessboard_pattern_gen #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .col_i        (col_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_value_o(pixel_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rotates the pixel about the frame center, picks the chessboard shades and
  // blends the four neighboring cells exactly as the hardware must.
  function automatic logic [PIX_W-1:0] predict_pixel(input logic [IN_W-1:0] col,
                                                     input logic [IN_W-1:0] row);
    longint coord_mask, dc, dr, xq, yq, ix, iy, fx, fy;
    longint shade_blk, shade_wht, c00, c01, c10, c11, total;
    longint px0, px1, py0, py1;
    logic   mid;
    coord_mask = (longint'(1) << COORD_BITS) - 1;
    dc = (longint'(col) & coord_mask) - longint'(frame_w >> 1);
    dr = (longint'(row) & coord_mask) - longint'(frame_h >> 1);
    // Floor division by 64 after adding half an LSB of Q.8.
    xq = (longint'(cos_w) * dc + longint'(sin_w) * dr + ROUND_Q8) >>> Q14_TO_Q8;
    yq = (-longint'(sin_w) * dc + longint'(cos_w) * dr + ROUND_Q8) >>> Q14_TO_Q8;
    ix = (xq >= 0) ? (xq >>> FRAC_W) : -((-xq) >>> FRAC_W);
    iy = (yq >= 0) ? (yq >>> FRAC_W) : -((-yq) >>> FRAC_W);
    fx = xq - ix * WEIGHT_ONE;
    fy = yq - iy * WEIGHT_ONE;
    mid = (xq > -MID_LIMIT) && (xq < MID_LIMIT) && (yq > -MID_LIMIT) && (yq < MID_LIMIT);
    shade_blk = mid ? longint'(SHADE_MID) : ix / 16;
    shade_wht = mid ? longint'(SHADE_MID) : PIX_MAX - iy / 16;
    px0 = (ix >>> CELL_SHIFT) & 1;
    px1 = ((ix + 1) >>> CELL_SHIFT) & 1;
    py0 = (iy >>> CELL_SHIFT) & 1;
    py1 = ((iy + 1) >>> CELL_SHIFT) & 1;
    c00 = ((px0 ^ py0) != 0) ? shade_wht : shade_blk;
    c01 = ((px1 ^ py0) != 0) ? shade_wht : shade_blk;
    c10 = ((px0 ^ py1) != 0) ? shade_wht : shade_blk;
    c11 = ((px1 ^ py1) != 0) ? shade_wht : shade_blk;
    total = (c00 * (WEIGHT_ONE - fx) + c01 * fx) * (WEIGHT_ONE - fy)
          + (c10 * (WEIGHT_ONE - fx) + c11 * fx) * fy + HALF_Q16;
    if (total < 0) begin
      return '0;
    end
    total = total >>> 16;
    return (total > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(total);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Records each accepted pixel and checks each delivered sample.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_pixels.push_back(predict_pixel(col_i, row_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected pixel", -1, pixel_value_o);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (pixel_value_o !== want_pixel) begin
            note_mismatch("pixel_value", want_pixel, pixel_value_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d samples outstanding",
               cycle_count, expected_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid is only lowered by an idle cycle or a drain, so it never drops and
  // rises again in the same step.
  task automatic send_pixel(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    col_i      <= col;
    row_i      <= row;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // Writes all four registers back to back; call only with the pipeline empty.
  task automatic write_frame_config(input logic [CFG_DATA_W-1:0] width,
                                    input logic [CFG_DATA_W-1:0] height,
                                    input logic [CFG_DATA_W-1:0] cos_val,
                                    input logic [CFG_DATA_W-1:0] sin_val);
    cfg_reg_e               idx;
    logic [CFG_DATA_W-1:0]  data;
    for (int k = 0; k < 4; k++) begin
      idx  = cfg_reg_e'(k);
      case (idx)
        REG_FRAME_WIDTH:  data = width;
        REG_FRAME_HEIGHT: data = height;
        REG_COS:          data = cos_val;
        default:          data = sin_val;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        REG_FRAME_WIDTH:  frame_w = data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_h = data[DIM_W-1:0];
        REG_COS:          cos_w   = data;
        default:          sin_w   = data;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return CFG_DATA_W'($urandom);
      1:       return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_trig();
    case ($urandom_range(7))
      0:       return CFG_DATA_W'($urandom);
      1:       return $urandom_range(1) ? CFG_DATA_W'(16384) : CFG_DATA_W'(-16384);
      default: return CFG_DATA_W'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Mostly inside the frame, some near the center, some anywhere.
  function automatic logic [IN_W-1:0] pick_coord(input int size);
    int sel;
    sel = $urandom_range(99);
    if (sel < 25 || size == 0) begin
      return IN_W'($urandom);
    end else if (sel < 40) begin
      return IN_W'((size >> 1) + int'($urandom_range(16)) - 8);
    end
    return IN_W'($urandom_range(0, ((size > 4096) ? 4096 : size) - 1));
  endfunction

  task automatic test_default_frame();
    // Corners of the coordinate range, the center block, its borders and the frame's last pixel.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd323, 12'd243);
    send_pixel(12'd324, 12'd240);
    send_pixel(12'd316, 12'd236);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd335, 12'd255);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    write_frame_config(16'd0, 16'd0, 16'h8000, 16'h7FFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd17);
    drain_pipeline();
    // Upper data bits of the frame sizes are dropped by the registers.
    write_frame_config(16'hFFFF, 16'hE000, 16'(-16384), 16'd16384);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd1);
    drain_pipeline();
    write_frame_config(16'd1, 16'd1, 16'd11585, 16'd11585);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd100, 12'd37);
    drain_pipeline();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 56; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 56; end
        default: begin send_idle_pct = 7; ready_stall_pct = 7; end
      endcase
      for (int seg = 0; seg < SEGMENTS / 4; seg++) begin
        write_frame_config(pick_size(), pick_size(), pick_trig(), pick_trig());
        repeat (RANDOM_ITEMS / SEGMENTS) begin
          send_pixel(pick_coord(int'(frame_w)), pick_coord(int'(frame_h)));
        end
        drain_pipeline();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_default_frame();
    test_register_extremes();
    test_random_phases();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
